// ===== rtl/core/hrt_pkg.sv =====
// Shared types and constants for the HTTP request header tokenizer.
// No dependencies. All core modules import this package.
package hrt_pkg;

    // Token kind codes carried on each result.
    typedef enum logic [2:0] {
        KIND_METHOD = 3'd0,
        KIND_PATH   = 3'd1,
        KIND_PROTO  = 3'd2,
        KIND_KEY    = 3'd3,
        KIND_VALUE  = 3'd4,
        KIND_END    = 3'd5
    } t_kind;

    // Characters that steer the parse.
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;

    // Result queue geometry: room for two results per input byte.
    localparam int RQ_DEPTH = 4;
    localparam int RQ_AW    = 2;
    localparam int RQ_CW    = 3;

    // One result item.
    typedef struct packed {
        logic [2:0] token_kind;
        logic       has_byte;
        logic [7:0] out_byte;
        logic       token_end;
        logic [4:0] field_index;
        logic       field_overflow;
    } t_result;

    // Results produced by one processed byte, in delivery order.
    typedef struct packed {
        logic [1:0] num;
        t_result    r0;
        t_result    r1;
    } t_push;

endpackage

// ===== rtl/core/hrt_ifs.sv =====
// Valid/ready channel interfaces for the tokenizer's byte input and result output.
// Depends on nothing but the port widths of the block.
interface hrt_req_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface hrt_tok_if;
    logic       valid;
    logic       ready;
    logic [2:0] token_kind;
    logic       has_byte;
    logic [7:0] out_byte;
    logic       token_end;
    logic [4:0] field_index;
    logic       field_overflow;

    modport source (output valid, output token_kind, output has_byte, output out_byte,
                    output token_end, output field_index, output field_overflow,
                    input ready);
    modport sink   (input valid, input token_kind, input has_byte, input out_byte,
                    input token_end, input field_index, input field_overflow,
                    output ready);
endinterface

// ===== rtl/core/hrt_step.sv =====
// Parse state registers and the per-byte step logic of the tokenizer.
// Depends on hrt_pkg; produces up to two results for each processed byte.
module hrt_step
    import hrt_pkg::*;
#(
    parameter int MAX_FIELDS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_go,
    input  logic [7:0] i_byte,
    output t_push      o_push
);

    localparam int CW = $clog2(MAX_FIELDS + 1);
    localparam logic [CW-1:0] LIMIT   = CW'(MAX_FIELDS);
    localparam logic [4:0]    TOP_IDX = 5'(MAX_FIELDS - 1);

    typedef enum logic [2:0] {
        PH_METHOD,
        PH_PATH,
        PH_PROTO,
        PH_LINE,
        PH_KEY,
        PH_VLEAD,
        PH_VALUE
    } t_phase;

    t_phase          r_phase, n_phase, ph;
    logic            r_held, n_held;
    logic [CW-1:0]   r_count, n_count;
    logic            w_ovf;
    logic [4:0]      w_idx;
    logic            cr_hit, main_hit;
    t_result         cr_res, main_res;

    function automatic t_kind phase_kind(input t_phase p);
        t_kind k;
        case (p)
            PH_PATH:            k = KIND_PATH;
            PH_PROTO:           k = KIND_PROTO;
            PH_LINE, PH_KEY:    k = KIND_KEY;
            PH_VLEAD, PH_VALUE: k = KIND_VALUE;
            default:            k = KIND_METHOD;
        endcase
        return k;
    endfunction

    function automatic t_result mk(input t_kind k, input logic h, input logic [7:0] b,
                                   input logic e, input logic [4:0] idx, input logic ovf);
        t_result r;
        logic    fld;
        fld              = (k == KIND_KEY) || (k == KIND_VALUE);
        r.token_kind     = k;
        r.has_byte       = h;
        r.out_byte       = h ? b : 8'h00;
        r.token_end      = e;
        r.field_index    = fld ? idx : 5'd0;
        r.field_overflow = fld & ovf;
        return r;
    endfunction

    // Field index of the header being parsed; pinned once the limit is reached
    assign w_ovf = (r_count >= LIMIT);
    assign w_idx = w_ovf ? TOP_IDX : 5'(r_count);

    // Resolve a held CR, then handle the byte itself
    always_comb begin
        n_held   = r_held;
        n_count  = r_count;
        cr_hit   = 1'b0;
        main_hit = 1'b0;
        cr_res   = '0;
        main_res = '0;
        ph       = r_phase;
        n_phase  = r_phase;

        if (r_held && (i_byte == CH_LF)) begin
            // CR LF: close the line
            n_held = 1'b0;
            case (r_phase)
                PH_PROTO: begin
                    main_hit = 1'b1;
                    main_res = mk(KIND_PROTO, 1'b0, 8'h00, 1'b1, w_idx, w_ovf);
                    n_phase  = PH_LINE;
                end
                PH_LINE: begin
                    main_hit = 1'b1;
                    main_res = mk(KIND_END, 1'b0, 8'h00, 1'b1, w_idx, w_ovf);
                    n_phase  = PH_METHOD;
                    n_count  = '0;
                end
                PH_VLEAD, PH_VALUE: begin
                    main_hit = 1'b1;
                    main_res = mk(KIND_VALUE, 1'b0, 8'h00, 1'b1, w_idx, w_ovf);
                    if (r_count < LIMIT) begin
                        n_count = r_count + CW'(1);
                    end
                    n_phase  = PH_LINE;
                end
                default: ;
            endcase
        end else begin
            // Lone CR becomes content of the current token
            if (r_held) begin
                n_held = 1'b0;
                if (r_phase inside {PH_PROTO, PH_LINE, PH_VLEAD, PH_VALUE}) begin
                    cr_hit = 1'b1;
                    cr_res = mk(phase_kind(r_phase), 1'b1, CH_CR, 1'b0, w_idx, w_ovf);
                    if (r_phase == PH_LINE) begin
                        ph = PH_KEY;
                    end else if (r_phase == PH_VLEAD) begin
                        ph = PH_VALUE;
                    end
                end
            end
            n_phase = ph;

            case (ph)
                PH_METHOD, PH_PATH: begin
                    main_hit = 1'b1;
                    if (i_byte == CH_SP) begin
                        main_res = mk(phase_kind(ph), 1'b0, 8'h00, 1'b1, w_idx, w_ovf);
                        n_phase  = (ph == PH_METHOD) ? PH_PATH : PH_PROTO;
                    end else begin
                        main_res = mk(phase_kind(ph), 1'b1, i_byte, 1'b0, w_idx, w_ovf);
                    end
                end
                PH_PROTO, PH_VALUE: begin
                    if (i_byte == CH_CR) begin
                        n_held = 1'b1;
                    end else begin
                        main_hit = 1'b1;
                        main_res = mk(phase_kind(ph), 1'b1, i_byte, 1'b0, w_idx, w_ovf);
                    end
                end
                PH_LINE, PH_KEY: begin
                    if ((ph == PH_LINE) && (i_byte == CH_CR)) begin
                        n_held = 1'b1;
                    end else if (i_byte == CH_COLON) begin
                        main_hit = 1'b1;
                        main_res = mk(KIND_KEY, 1'b0, 8'h00, 1'b1, w_idx, w_ovf);
                        n_phase  = PH_VLEAD;
                    end else begin
                        main_hit = 1'b1;
                        main_res = mk(KIND_KEY, 1'b1, i_byte, 1'b0, w_idx, w_ovf);
                        n_phase  = PH_KEY;
                    end
                end
                PH_VLEAD: begin
                    // Drop leading spaces of a value
                    if (i_byte == CH_CR) begin
                        n_held = 1'b1;
                    end else if (i_byte != CH_SP) begin
                        main_hit = 1'b1;
                        main_res = mk(KIND_VALUE, 1'b1, i_byte, 1'b0, w_idx, w_ovf);
                        n_phase  = PH_VALUE;
                    end
                end
                default: begin
                    n_phase = PH_METHOD;
                end
            endcase
        end
    end

    // Pack results in delivery order
    always_comb begin
        o_push.num = i_go ? (2'(cr_hit) + 2'(main_hit)) : 2'd0;
        o_push.r0  = cr_hit ? cr_res : main_res;
        o_push.r1  = main_res;
    end

    // Hold parse state; advance on each processed byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_METHOD;
            r_held  <= 1'b0;
            r_count <= '0;
        end else if (i_go) begin
            r_phase <= n_phase;
            r_held  <= n_held;
            r_count <= n_count;
        end
    end

endmodule

// ===== rtl/core/hrt_rq.sv =====
// Result queue: four entries, up to two writes and one read per cycle.
// Depends on hrt_pkg for the result and push types.
module hrt_rq
    import hrt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    output logic    o_room,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_head
);

    t_result            r_mem [RQ_DEPTH];
    logic [RQ_AW-1:0]   r_wr, r_rd;
    logic [RQ_CW-1:0]   r_cnt;
    logic               w_pop;

    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd];
    assign w_pop   = o_valid && i_ready;
    // Room for the worst case of two results from one byte
    assign o_room  = (r_cnt <= RQ_CW'(RQ_DEPTH - 2));

    // Write entries in order
    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) begin
            r_mem[r_wr] <= i_push.r0;
        end
        if (i_push.num == 2'd2) begin
            r_mem[r_wr + RQ_AW'(1)] <= i_push.r1;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + RQ_AW'(i_push.num);
            r_rd  <= r_rd + RQ_AW'(w_pop);
            r_cnt <= r_cnt + RQ_CW'(i_push.num) - RQ_CW'(w_pop);
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= RQ_CW'(RQ_DEPTH))
        else $error("result queue occupancy beyond depth");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.num != 2'd0) |-> (r_cnt - RQ_CW'(w_pop) <= RQ_CW'(RQ_DEPTH - 2)))
        else $error("results written without room");

endmodule

// ===== rtl/core/http_request_header_tokenizer.sv =====
// Top level of the HTTP request header tokenizer: input register, step logic, result queue.
// Depends on hrt_pkg, hrt_ifs, hrt_step and hrt_rq.

// The tokenizer takes one request byte per input transfer and gives zero, one or two
// results for it, one result per output transfer. It labels content bytes and marks
// token ends and the end of each request. While the result side is always ready, a byte is
// accepted in every cycle. A held CR gives no result on its own cycle. The byte after a
// lone CR gives two results, and it always follows that CR byte. So the four-entry result
// queue never holds more than two results and always has room, and input stalls come only
// from back-pressure on the result channel. A result can be accepted at the earliest once
// its byte has passed the input register and then the result queue, and later when results
// are queued ahead of it. The header counter saturates at MAX_FIELDS; later fields report
// the top index with the overflow flag set.
module http_request_header_tokenizer
    import hrt_pkg::*;
#(
    parameter int MAX_FIELDS = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    hrt_req_if.sink         i_req,
    hrt_tok_if.source       o_tok
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       w_room;
    logic       w_go;
    logic       w_in_ready;
    t_push      w_push;
    t_result    w_head;

    // Process the held byte when the queue can take its results
    assign w_go       = r_in_valid && w_room;
    assign w_in_ready = !r_in_valid || w_go;
    assign i_req.ready = w_in_ready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_ready && i_req.valid) begin
            r_in_byte <= i_req.data_byte;
        end
    end

    hrt_step #(
        .MAX_FIELDS (MAX_FIELDS)
    ) u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (w_go),
        .i_byte  (r_in_byte),
        .o_push  (w_push)
    );

    hrt_rq u_rq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_room  (w_room),
        .o_valid (o_tok.valid),
        .i_ready (o_tok.ready),
        .o_head  (w_head)
    );

    // Drive the result channel from the queue head
    assign o_tok.token_kind     = w_head.token_kind;
    assign o_tok.has_byte       = w_head.has_byte;
    assign o_tok.out_byte       = w_head.out_byte;
    assign o_tok.token_end      = w_head.token_end;
    assign o_tok.field_index    = w_head.field_index;
    assign o_tok.field_overflow = w_head.field_overflow;

    a_end_no_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_tok.valid && o_tok.token_end) |-> !o_tok.has_byte)
        else $error("token end result carries a content byte");

    a_ovf_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_tok.valid && o_tok.field_overflow) |->
            ((o_tok.token_kind == KIND_KEY) || (o_tok.token_kind == KIND_VALUE)))
        else $error("overflow flag on a non-field result");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_room) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("stalled input byte lost or changed");

endmodule
